// File: src/sol_pkg.sv
// Shared constants, codes and command types for the sorted offset list.
package sol_pkg;

   localparam int CAPACITY      = 64;
   localparam int OFFSET_W      = 31;
   localparam int ENTRY_COUNT_W = 7;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DELETE  = 2'd1,
      KIND_REPLACE = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REINSERT,
      ST_LOAD
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       use_repl;
      logic       capture;
      status_type status;
      logic       load;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic found;
   } dp_flags_type;

endpackage

// File: src/sol_datapath.sv
// Row of sorted entry cells with count, request capture and result register.
module sol_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  sol_pkg::dp_cmd_type                 cmd,
   output sol_pkg::dp_flags_type               flags,
   input  logic [sol_pkg::OFFSET_W-1:0]        req_offset_value,
   input  logic [sol_pkg::OFFSET_W-1:0]        req_replacement_value,
   output logic [sol_pkg::OFFSET_W-1:0]        rsp_smallest_offset,
   output logic [sol_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   output sol_pkg::status_type                 rsp_status
);
   import sol_pkg::*;

   logic [OFFSET_W-1:0] entries_ff [CAPACITY];
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [OFFSET_W-1:0] repl_ff;
   status_type          status_ff;
   logic [OFFSET_W-1:0] smallest_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   status_type          rsp_status_ff;

   logic [OFFSET_W-1:0] ins_value;
   logic [CAPACITY-1:0] valid, gt, eq, ge;
   logic [CAPACITY-2:0] order_ok;

   assign ins_value = cmd.use_repl ? repl_ff : req_offset_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                prev_gt;
      logic [OFFSET_W-1:0] prev_entry;
      logic [OFFSET_W-1:0] next_entry;
      logic                at_end;
      logic [OFFSET_W-1:0] entry_in;

      assign valid[i] = COUNT_W'(i) < count_ff;
      assign gt[i]    = valid[i] && (entries_ff[i] > ins_value);
      assign eq[i]    = valid[i] && (entries_ff[i] == req_offset_value);
      assign ge[i]    = valid[i] && (entries_ff[i] >= req_offset_value);
      assign at_end   = COUNT_W'(i) == count_ff;

      if (i == 0) begin : g_first
         assign prev_gt    = 1'b0;
         assign prev_entry = '0;
      end else begin : g_rest
         assign prev_gt    = gt[i-1];
         assign prev_entry = entries_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = entries_ff[i+1];
         assign order_ok[i] = !valid[i+1] || (entries_ff[i] <= entries_ff[i+1]);
      end

      always_comb begin
         entry_in = entries_ff[i];
         unique case (cmd.op)
            OP_INSERT: begin
               // shift larger entries up one place, drop the new value in the gap
               if (prev_gt) begin
                  entry_in = prev_entry;
               end else if (gt[i] || at_end) begin
                  entry_in = ins_value;
               end
            end
            OP_DELETE: begin
               // entries from the first match on move down one place
               if (ge[i]) begin
                  entry_in = next_entry;
               end
            end
            default: ;
         endcase
      end

      if (i == 0) begin : g_reg_first
         always_ff @(posedge clock) begin
            if (reset) begin
               entries_ff[i] <= '0;
            end else begin
               entries_ff[i] <= entry_in;
            end
         end
      end else begin : g_reg_rest
         always_ff @(posedge clock) begin
            entries_ff[i] <= entry_in;
         end
      end
   end

   assign flags.full  = count_ff >= COUNT_W'(CAPACITY);
   assign flags.found = |eq;

   always_comb begin
      count_in = count_ff;
      unique case (cmd.op)
         OP_INSERT: count_in = count_ff + COUNT_W'(1);
         OP_DELETE: count_in = count_ff - COUNT_W'(1);
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         repl_ff   <= req_replacement_value;
         status_ff <= cmd.status;
      end
      if (cmd.load) begin
         smallest_ff   <= (count_ff != '0) ? entries_ff[0] : '0;
         rsp_count_ff  <= ENTRY_COUNT_W'(count_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_smallest_offset = smallest_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_status          = rsp_status_ff;

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   list_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("held entries out of ascending order");

   delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DELETE |-> flags.found ##1 count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("delete without match or count not reduced");

endmodule

// File: src/sol_ctrl.sv
// Request sequencer: accepts a transfer, issues list operations, loads the result.
module sol_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sol_pkg::kind_type     req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sol_pkg::dp_flags_type flags,
   output sol_pkg::dp_cmd_type   cmd
);
   import sol_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd.op       = OP_NONE;
      cmd.use_repl = 1'b0;
      cmd.capture  = 1'b0;
      cmd.status   = STATUS_OK;
      cmd.load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // hold off transfers while reset is applied
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
               unique case (req_kind)
                  KIND_INSERT: begin
                     if (flags.full) begin
                        cmd.status = STATUS_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  KIND_DELETE: begin
                     if (flags.found) begin
                        cmd.op = OP_DELETE;
                     end else begin
                        cmd.status = STATUS_NOT_FOUND;
                     end
                  end
                  KIND_REPLACE: begin
                     // remove the old offset now, put the new one in next cycle
                     if (flags.found) begin
                        cmd.op   = OP_DELETE;
                        state_in = ST_REINSERT;
                     end else begin
                        cmd.status = STATUS_NOT_FOUND;
                     end
                  end
                  KIND_QUERY: ;
               endcase
            end
         end
         ST_REINSERT: begin
            cmd.op       = OP_INSERT;
            cmd.use_repl = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   reinsert_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REINSERT |-> $past(state_ff) == ST_IDLE && $past(req_valid))
      else $error("reinsert step without a preceding replace transfer");

   rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result dropped while stalled");

   busy_stalls_input: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request transfer possible while busy");

endmodule

// File: src/sorted_offset_list.sv
// A request transfer leads to the load state (via the reinsert state for replace),
// which loads the result register once it is free. No new request is taken until
// that load; the sequencer steps through one shift pass of the entry cell row per
// list operation. A pending result does not block a transfer, but holds its load.
// Reset: list holds a single zero offset, count one; no clearing pass.
module sorted_offset_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sol_pkg::kind_type                   req_kind,
   input  logic [sol_pkg::OFFSET_W-1:0]        req_offset_value,
   input  logic [sol_pkg::OFFSET_W-1:0]        req_replacement_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sol_pkg::OFFSET_W-1:0]        rsp_smallest_offset,
   output logic [sol_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   output sol_pkg::status_type                 rsp_status
);
   import sol_pkg::*;

   dp_cmd_type   cmd;
   dp_flags_type flags;

   sol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   sol_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .flags                 (flags),
      .req_offset_value      (req_offset_value),
      .req_replacement_value (req_replacement_value),
      .rsp_smallest_offset   (rsp_smallest_offset),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_status            (rsp_status)
   );

endmodule
